>>> sv/dbsms_pkg.sv
// dbsms_pkg: shared types, constants and control structs for the
// dc-blocked stereo mean-square meter. No dependencies.
package dbsms_pkg;

  localparam int MAX_BLOCK_DEF = 4096;
  localparam int SAMPLE_SHIFT  = 8;
  localparam int RAW_W         = 32;
  localparam int SAMPLE_W      = RAW_W - SAMPLE_SHIFT;  // Q1.23
  localparam int FRAC_EXT      = 16;                    // Q1.23 -> Q2.39
  localparam int ALPHA_W       = 16;
  localparam int DC_W          = 41;                    // Q2.39 plus sign room
  localparam int PROD_W        = DC_W + ALPHA_W + 1;
  localparam int E23_W         = DC_W - FRAC_EXT;       // Q2.23 residue
  localparam int SQ_W          = 33;                    // Q3.30 square, up to 2^32
  localparam int MEAN_W        = 32;
  localparam int BCNT_W        = 13;

  localparam logic [ALPHA_W-1:0] DC_ALPHA_RST = 16'd64;

  typedef struct packed {
    logic signed [RAW_W-1:0] sample_left;
    logic signed [RAW_W-1:0] sample_right;
    logic                    last_sample;
  } in_beat_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean_square_left;
    logic [MEAN_W-1:0] mean_square_right;
    logic [BCNT_W-1:0] block_count;
    logic              forced_end;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_SQR,
    ST_ACC,
    ST_DIV,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic upd;
    logic sqr;
    logic acc;
    logic div;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic end_now;
    logic div_last;
  } stat_t;

endpackage

>>> sv/dbsms_chan.sv
// dbsms_chan: one audio channel: dc tracker, squared residue, running sum
// and a restoring divider working in place on the sum. Uses dbsms_pkg.
module dbsms_chan
  import dbsms_pkg::*;
#(
  parameter int CNT_W = 13
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  input  logic [RAW_W-1:0]    raw,
  input  logic [ALPHA_W-1:0]  alpha,
  input  logic [CNT_W-1:0]    divisor,
  output logic [MEAN_W-1:0]   mean
);

  localparam int SUM_W = SQ_W + CNT_W;

  logic signed [SAMPLE_W-1:0]  x;
  logic signed [DC_W-1:0]      x39;
  logic signed [DC_W-1:0]      dc;
  logic signed [DC_W-1:0]      d;
  logic signed [PROD_W-1:0]    prod;
  logic signed [DC_W-1:0]      step;
  logic signed [DC_W-1:0]      e_full;
  logic signed [E23_W-1:0]     e23;
  logic signed [2*E23_W-1:0]   sq_full;
  logic [SQ_W-1:0]             sq;
  logic [SUM_W-1:0]            sum;
  logic [CNT_W-1:0]            rem;
  logic [CNT_W:0]              rem_sh;
  logic [CNT_W:0]              rem_sub;
  logic                        ge;

  assign x       = raw[RAW_W-1:SAMPLE_SHIFT];
  assign x39     = {x[SAMPLE_W-1], x, {FRAC_EXT{1'b0}}};
  // floor(prod / 2^16)
  assign step    = prod[DC_W+FRAC_EXT-1:FRAC_EXT];
  // residue against the updated dc: x39 - (dc + step) = d - step
  assign e_full  = d - step;
  assign sq_full = e23 * e23;

  assign rem_sh  = {rem, sum[SUM_W-1]};
  assign ge      = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  assign mean = (|sum[SUM_W-1:MEAN_W]) ? {MEAN_W{1'b1}} : sum[MEAN_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d <= x39 - dc;
    end
    if (cmd.mul) begin
      prod <= d * $signed({1'b0, alpha});
    end
    if (cmd.upd) begin
      e23 <= e_full[DC_W-1:FRAC_EXT];
    end
    if (cmd.sqr) begin
      sq <= sq_full[SQ_W+FRAC_EXT-1:FRAC_EXT];
    end
    if (cmd.acc) begin
      rem <= '0;
    end else if (cmd.div) begin
      rem <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dc  <= '0;
      sum <= '0;
    end else begin
      if (cmd.upd) begin
        dc <= dc + step;
      end
      if (cmd.acc) begin
        sum <= sum + SUM_W'(sq);
      end else if (cmd.div) begin
        // quotient bits shift in from the bottom
        sum <= {sum[SUM_W-2:0], ge};
      end else if (cmd.out_load) begin
        sum <= '0;
      end
    end
  end

endmodule

>>> sv/dbsms_datapath.sv
// dbsms_datapath: coefficient register, pair count, divide step counter,
// result register and the two channel units. Uses dbsms_pkg, dbsms_chan.
module dbsms_datapath
  import dbsms_pkg::*;
#(
  parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  in_beat_t           in_data,
  output out_beat_t          out_data,
  input  logic               cfg_wr_en,
  input  logic [ALPHA_W-1:0] cfg_wr_data
);

  localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
  localparam int SUM_W  = SQ_W + CNT_W;
  localparam int ITER_W = $clog2(SUM_W);

  logic [ALPHA_W-1:0]    alpha;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_inc;
  logic [CNT_W+BCNT_W-1:0] count_ext;
  logic                  last_flag;
  logic [ITER_W-1:0]     iter;
  logic [RAW_W-1:0]      raw_left;
  logic [RAW_W-1:0]      raw_right;
  logic [MEAN_W-1:0]     mean_left;
  logic [MEAN_W-1:0]     mean_right;

  assign raw_left  = in_data.sample_left;
  assign raw_right = in_data.sample_right;
  assign count_inc = count + CNT_W'(1);
  assign count_ext = {{BCNT_W{1'b0}}, count};

  assign stat.end_now  = last_flag || (count_inc >= CNT_W'(MAX_BLOCK));
  assign stat.div_last = (iter == ITER_W'(SUM_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= DC_ALPHA_RST;
      count <= '0;
    end else begin
      if (cfg_wr_en) begin
        alpha <= cfg_wr_data;
      end
      if (cmd.acc) begin
        count <= count_inc;
      end else if (cmd.out_load) begin
        count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      last_flag <= in_data.last_sample;
    end
    if (cmd.acc) begin
      iter <= '0;
    end else if (cmd.div) begin
      iter <= iter + ITER_W'(1);
    end
    if (cmd.out_load) begin
      out_data.mean_square_left  <= mean_left;
      out_data.mean_square_right <= mean_right;
      out_data.block_count       <= count_ext[BCNT_W-1:0];
      out_data.forced_end        <= ~last_flag;
    end
  end

  dbsms_chan #(
    .CNT_W(CNT_W)
  ) u_chan_left (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .raw     (raw_left),
    .alpha   (alpha),
    .divisor (count),
    .mean    (mean_left)
  );

  dbsms_chan #(
    .CNT_W(CNT_W)
  ) u_chan_right (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .raw     (raw_right),
    .alpha   (alpha),
    .divisor (count),
    .mean    (mean_right)
  );

endmodule

>>> sv/dbsms_ctrl.sv
// dbsms_ctrl: sequencing state machine and result-valid flag.
// Uses dbsms_pkg.
module dbsms_ctrl
  import dbsms_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd    = 1'b1;
        state_next = ST_SQR;
      end
      ST_SQR: begin
        cmd.sqr    = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc    = 1'b1;
        state_next = stat.end_now ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (stat.div_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

>>> sv/dc_blocked_stereo_mean_square_unit.sv
// dc_blocked_stereo_mean_square_unit: top level of the stereo dc-blocked
// mean-square meter. Uses dbsms_pkg, dbsms_ctrl, dbsms_datapath.
//
//   channel   direction  handshake              payload
//   in        sink       in_valid / in_ready    in_data  (in_beat_t)
//   out       source     out_valid / out_ready  out_data (out_beat_t)
//   cfg       sink       cfg_wr_en only         cfg_wr_data (dc_alpha)
//
// each input beat passes through accept, alpha multiply, dc update, residue
// square and accumulate, one state each, before a new beat is taken;
// a beat that closes a block then runs the bit-per-cycle restoring divide
// and, once the result register is free, loads the result out
// reset is synchronous: dc trackers, sums and count clear, dc_alpha goes to 64
// the result register lets the next input beat be taken while a result waits;
// only a second block end stalls, until the waiting result is taken
module dc_blocked_stereo_mean_square_unit
  import dbsms_pkg::*;
#(
  parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_beat_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_beat_t          out_data,
  input  logic               cfg_wr_en,
  input  logic [ALPHA_W-1:0] cfg_wr_data
);

  // command and status bundles between sequencer and datapath
  cmd_t  cmd;
  stat_t stat;

  // sequencer: one pair at a time, then the divide when a block closes
  dbsms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic, counters, coefficient and result registers
  dbsms_datapath #(
    .MAX_BLOCK(MAX_BLOCK)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_data     (in_data),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken beat");

  // only one step of the sequence is commanded at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.mul, cmd.upd, cmd.sqr, cmd.acc, cmd.div, cmd.out_load}))
    else $error("overlapping datapath commands");

  // an accepted beat is followed by its multiply step, not another accept
  a_accept_then_mul: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (cmd.mul && !in_ready))
    else $error("input beat not followed by multiply step");

  // a freshly loaded result is presented on the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

endmodule
